>>> hdl/du64_pkg.sv
package du64_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    localparam int STEP_CNT_W = $clog2(DIVIDEND_W);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new item and clear the partial remainder
        logic step;   // produce one quotient bit
        logic xfer;   // move the finished result into the output register
    } du64_cmd_t;

endpackage

>>> hdl/du64_datapath.sv
module du64_datapath (
    input  logic                               aclk,
    input  du64_pkg::du64_cmd_t                cmd,
    input  logic [du64_pkg::DIVIDEND_W-1:0]    s_dividend,
    input  logic [du64_pkg::DIVISOR_W-1:0]     s_divisor,
    output logic [du64_pkg::DIVIDEND_W-1:0]    m_quotient,
    output logic [du64_pkg::DIVISOR_W-1:0]     m_leftover,
    output logic                               m_divide_error
);

    // Working registers: quo_reg starts as the dividend and fills with quotient bits
    logic [du64_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [du64_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [du64_pkg::DIVISOR_W-1:0]  den_reg;
    logic                            err_reg;

    // Output registers
    logic [du64_pkg::DIVIDEND_W-1:0] out_quo_reg;
    logic [du64_pkg::DIVISOR_W-1:0]  out_rem_reg;
    logic                            out_err_reg;

    logic [du64_pkg::DIVISOR_W:0]    rem_ext;
    logic [du64_pkg::DIVISOR_W+1:0]  diff;
    logic                            fits;

    always_comb begin
        rem_ext  = {rem_reg, quo_reg[du64_pkg::DIVIDEND_W-1]};
        diff     = {1'b0, rem_ext} - {2'b00, den_reg};
        fits     = ~diff[du64_pkg::DIVISOR_W+1];
        rem_next = fits ? diff[du64_pkg::DIVISOR_W-1:0] : rem_ext[du64_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[du64_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quo_reg <= s_dividend;
            rem_reg <= '0;
            den_reg <= s_divisor;
            err_reg <= (s_divisor == '0);
        end else if (cmd.step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.xfer) begin
            out_quo_reg <= err_reg ? '1 : quo_reg;
            out_rem_reg <= err_reg ? '0 : rem_reg;
            out_err_reg <= err_reg;
        end
    end

    assign m_quotient     = out_quo_reg;
    assign m_leftover     = out_rem_reg;
    assign m_divide_error = out_err_reg;

endmodule

>>> hdl/du64_ctrl.sv
module du64_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output du64_pkg::du64_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_XFER = 2'd2;

    localparam logic [du64_pkg::STEP_CNT_W-1:0] LAST_STEP =
        du64_pkg::STEP_CNT_W'(du64_pkg::DIVIDEND_W - 1);

    logic [1:0]                      state_reg, state_next;
    logic [du64_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER: begin
                // hold until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.xfer     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_load_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("accepted item did not start the step sequence");

    a_last_step_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg == LAST_STEP) |=> (state_reg == ST_XFER))
        else $error("step sequence did not end after the last quotient bit");

    a_xfer_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.xfer |=> m_valid)
        else $error("result transfer did not raise m_valid");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.xfer}))
        else $error("more than one datapath command at once");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.xfer && m_valid) |-> m_ready)
        else $error("output register overwritten before it was taken");
`endif

endmodule

>>> hdl/divide_u64_by_u32.sv
// Unsigned 64-by-32 divider: takes a 64-bit dividend and a 32-bit divisor and
// returns the 64-bit quotient and the 32-bit remainder (leftover). A zero
// divisor raises divide_error with an all-ones quotient and zero remainder.
// The core is a restoring shift-subtract loop that produces one quotient bit
// per clock. Accepting an item loads the operands, the steps then produce the
// quotient bits one by one, and the finished result is moved into the output
// register. s_ready rises again right after that transfer, so a new item is
// not accepted before the previous one has reached the output register. The
// next item can start while the previous result still waits on m_ready; if
// that result is still waiting when the next one finishes, the transfer holds
// until it is taken and the input stays closed meanwhile.
module divide_u64_by_u32 (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [du64_pkg::DIVIDEND_W-1:0] s_dividend,
    input  logic [du64_pkg::DIVISOR_W-1:0]  s_divisor,
    // result item channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [du64_pkg::DIVIDEND_W-1:0] m_quotient,
    output logic [du64_pkg::DIVISOR_W-1:0]  m_leftover,
    output logic                            m_divide_error
);

    // load / step / transfer commands from the sequencer
    du64_pkg::du64_cmd_t cmd;

    // Sequencer: accept an item, count the 64 steps, hand off the result
    du64_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: shared subtractor, working registers and output register
    du64_datapath u_datapath (
        .aclk           (aclk),
        .cmd            (cmd),
        .s_dividend     (s_dividend),
        .s_divisor      (s_divisor),
        .m_quotient     (m_quotient),
        .m_leftover     (m_leftover),
        .m_divide_error (m_divide_error)
    );

endmodule
